### rtl/aob_pkg.sv
// aob_pkg: shared widths, constants and the record carried along the divider chain.
// No dependencies; aob_prep, aob_div_cell and alpha_over_blend import it.
`timescale 1ns / 1ps

package aob_pkg;

    localparam int CHAN_W   = 8;
    localparam int WEIGHT_W = 16;
    localparam int REM_W    = 24;
    localparam int NUM_CHAN = 3;
    localparam int NUM_CELL = CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // One pixel pair in flight through the divider cells
    typedef struct packed {
        logic [NUM_CHAN-1:0][REM_W-1:0]  rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] quo;
        logic [WEIGHT_W-1:0]             den;
        logic [CHAN_W-1:0]               alpha;
    } t_cell_data;

endpackage

### rtl/aob_if.sv
// aob_in_if / aob_out_if: valid-ready channels for pixel pairs and composited pixels.
// No dependencies.
`timescale 1ns / 1ps

interface aob_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (output valid, src_red, src_green, src_blue, src_alpha,
                    dst_red, dst_green, dst_blue, dst_alpha, input ready);
    modport sink   (input valid, src_red, src_green, src_blue, src_alpha,
                    dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface aob_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

### rtl/aob_prep.sv
// aob_prep: two-stage front end forming blend weights, numerators, divisor and alpha.
// Depends on aob_pkg.
`timescale 1ns / 1ps

module aob_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [7:0]            i_src_red,
    input  logic [7:0]            i_src_green,
    input  logic [7:0]            i_src_blue,
    input  logic [7:0]            i_src_alpha,
    input  logic [7:0]            i_dst_red,
    input  logic [7:0]            i_dst_green,
    input  logic [7:0]            i_dst_blue,
    input  logic [7:0]            i_dst_alpha,
    output logic                  o_valid,
    output aob_pkg::t_cell_data   o_data
);
    import aob_pkg::*;

    logic                              r_a_valid;
    logic [WEIGHT_W-1:0]               r_ws;
    logic [WEIGHT_W-1:0]               r_wd;
    logic [CHAN_W-1:0]                 r_sa;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   r_cs;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   r_cd;
    logic [WEIGHT_W-1:0]               n_ws;
    logic [WEIGHT_W-1:0]               n_wd;
    logic                              r_b_valid;
    t_cell_data                        r_b;
    t_cell_data                        n_b;
    logic [WEIGHT_W:0]                 div_sum;
    logic [CHAN_W-1:0]                 wd_div;

    // Stage A: source and destination weights
    assign n_ws = WEIGHT_W'(i_src_alpha * CHAN_MAX);
    assign n_wd = WEIGHT_W'(i_dst_alpha * (CHAN_MAX - i_src_alpha));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ws <= n_ws;
            r_wd <= n_wd;
            r_sa <= i_src_alpha;
            r_cs <= {i_src_blue, i_src_green, i_src_red};
            r_cd <= {i_dst_blue, i_dst_green, i_dst_red};
        end
    end

    // Stage B: numerators, divisor, and alpha with wd/255 by the shift-add identity
    assign div_sum = {1'b0, r_wd} + (WEIGHT_W+1)'(r_wd >> 8) + (WEIGHT_W+1)'(1);
    assign wd_div  = div_sum[15:8];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_b.rem[c] = REM_W'(r_cs[c] * r_ws) + REM_W'(r_cd[c] * r_wd);
            n_b.quo[c] = '0;
        end
        n_b.den   = r_ws + r_wd;
        n_b.alpha = r_sa + wd_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

### rtl/aob_div_cell.sv
// aob_div_cell: one restoring-division step for all three color channels.
// Depends on aob_pkg.
`timescale 1ns / 1ps

module aob_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  aob_pkg::t_cell_data i_data,
    output logic                o_valid,
    output aob_pkg::t_cell_data o_data
);
    import aob_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [REM_W-1:0] den_top;

    // Compare against the divisor aligned to the top quotient bit, then shift
    assign den_top = {1'b0, i_data.den, 7'b0};

    always_comb begin
        n_data = i_data;
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (i_data.rem[c] >= den_top) begin
                n_data.rem[c] = (i_data.rem[c] - den_top) << 1;
                n_data.quo[c] = {i_data.quo[c][CHAN_W-2:0], 1'b1};
            end else begin
                n_data.rem[c] = i_data.rem[c] << 1;
                n_data.quo[c] = {i_data.quo[c][CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/alpha_over_blend.sv
// alpha_over_blend: Porter-Duff over of two straight-alpha RGBA pixels.
// Pipeline: two front-end stages, then eight divider cells, one quotient bit each.
// Throughput one pixel pair per cycle; the whole chain holds together while output stalls.
// Synchronous active-low reset clears all valid flags; data registers are not reset.
// Depends on aob_pkg, aob_if, aob_prep, aob_div_cell.
`timescale 1ns / 1ps

module alpha_over_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aob_in_if.sink      i_src,
    aob_out_if.source   o_res
);
    import aob_pkg::*;

    logic                      advance;
    logic [NUM_CELL:0]         cell_valid;
    t_cell_data [NUM_CELL:0]   cell_data;
    logic                      den_zero;

    // Advance the whole chain whenever the output slot is free or being taken
    assign advance     = !cell_valid[NUM_CELL] || o_res.ready;
    assign i_src.ready = advance;

    aob_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_valid     (i_src.valid),
        .i_src_red   (i_src.src_red),
        .i_src_green (i_src.src_green),
        .i_src_blue  (i_src.src_blue),
        .i_src_alpha (i_src.src_alpha),
        .i_dst_red   (i_src.dst_red),
        .i_dst_green (i_src.dst_green),
        .i_dst_blue  (i_src.dst_blue),
        .i_dst_alpha (i_src.dst_alpha),
        .o_valid     (cell_valid[0]),
        .o_data      (cell_data[0])
    );

    // Chain of divider cells, MSB of the quotient first
    for (genvar g = 0; g < NUM_CELL; g++) begin : g_cell
        aob_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    // Force colors to zero when both alphas are zero
    assign den_zero        = (cell_data[NUM_CELL].den == '0);
    assign o_res.valid     = cell_valid[NUM_CELL];
    assign o_res.out_red   = den_zero ? '0 : cell_data[NUM_CELL].quo[0];
    assign o_res.out_green = den_zero ? '0 : cell_data[NUM_CELL].quo[1];
    assign o_res.out_blue  = den_zero ? '0 : cell_data[NUM_CELL].quo[2];
    assign o_res.out_alpha = cell_data[NUM_CELL].alpha;

endmodule
